/* sv/scp_pkg.sv */
`default_nettype none

package scp_pkg;

  localparam int SCP_SCOPE_COUNT = 32;
  localparam int SCP_TIME_BITS   = 48;

  localparam int TS_W    = 48;
  localparam int ID_W    = 5;
  localparam int CNT_W   = 16;
  localparam int DEPTH_W = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 5;

  localparam logic [1:0] MODE_ENTER = 2'd0;
  localparam logic [1:0] MODE_LEAVE = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [KIND_W-1:0] PK_CALL = 2'd1;
  localparam logic [KIND_W-1:0] PK_DISC = 2'd2;

  localparam logic [KIND_W-1:0] RK_TARGET = 2'd0;
  localparam logic [KIND_W-1:0] RK_CHILD  = 2'd1;
  localparam logic [KIND_W-1:0] RK_ROOT   = 2'd2;

  localparam logic CFG_PROFILE_KIND = 1'b0;
  localparam logic CFG_TARGET_SCOPE = 1'b1;

  function automatic logic [DEPTH_W-1:0] inc_sat8(input logic [DEPTH_W-1:0] v);
    return (v != '1) ? v + DEPTH_W'(1) : v;
  endfunction

  function automatic logic [DEPTH_W-1:0] dec_hold8(input logic [DEPTH_W-1:0] v);
    return (v != '0) ? v - DEPTH_W'(1) : v;
  endfunction

  function automatic logic [CNT_W-1:0] inc_sat16(input logic [CNT_W-1:0] v);
    return (v != '1) ? v + CNT_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

/* sv/scp_ram.sv */
`default_nettype none

module scp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic                                        rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/scope_call_profiler_unit.sv */
`default_nettype none

// Scope call profiler. Enter and leave words in call mode read the per-scope statistics
// RAM in the accepting cycle, and any write-back is done in the next; no new word is
// taken in between. Enter and leave words in discovery mode, and words with profiling
// off or with an unused mode, are handled in the accepting cycle. A frame-end word in
// call mode emits the target word and then scans the child table entry by entry,
// reading the RAM for each valid child before emitting its word; the scan stops after
// the last valid entry, and no new word is taken until the dump ends. In discovery mode
// the scan emits a word for each root scope seen. Table reset is held in valid bits, so
// no clearing pass runs after reset or after a frame end.
module scope_call_profiler_unit import scp_pkg::*; #(
  parameter int SCOPE_COUNT = SCP_SCOPE_COUNT,
  parameter int TIME_BITS   = SCP_TIME_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_mode,
  input  wire logic [ID_W-1:0]   in_scope_id,
  input  wire logic [TS_W-1:0]   in_timestamp,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KIND_W-1:0]      out_result_kind,
  output logic [ID_W-1:0]        out_result_scope,
  output logic [TS_W-1:0]        out_total_time,
  output logic [CNT_W-1:0]       out_enter_count,
  output logic                   out_last
);

  localparam int AW = (SCOPE_COUNT > 1) ? $clog2(SCOPE_COUNT) : 1;
  localparam int RW = 2 * TIME_BITS + CNT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(SCOPE_COUNT - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DTGT  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CEMIT = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [KIND_W-1:0]      kind_r;
  logic [ID_W-1:0]        tgt_r;

  logic                   ev_leave_r;
  logic [ID_W-1:0]        ev_sid_r;
  logic [TIME_BITS-1:0]   ev_ts_r;

  logic [DEPTH_W-1:0]     root_depth_r, root_depth_nxt;
  logic [DEPTH_W-1:0]     tnest_r, tnest_nxt;
  logic [DEPTH_W-1:0]     dbt_r, dbt_nxt;
  logic [TIME_BITS-1:0]   tstart_r, tstart_nxt;
  logic [TIME_BITS-1:0]   tsum_r, tsum_nxt;
  logic [CNT_W-1:0]       tent_r, tent_nxt;
  logic [SCOPE_COUNT-1:0] child_valid_r, child_valid_nxt;
  logic [SCOPE_COUNT-1:0] root_seen_r, root_seen_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]      out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]        out_scope_r, out_scope_nxt;
  logic [TS_W-1:0]        out_time_r, out_time_nxt;
  logic [CNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_load;

  logic                   in_fire;
  logic                   in_tab, ev_tab, ev_valid, ev_tgt;
  logic [AW-1:0]          in_sa, ev_sa;
  logic [TIME_BITS-1:0]   in_ts;
  logic [DEPTH_W-1:0]     dbt_up;
  logic [SCOPE_COUNT-1:0] idx_bit;
  logic                   can_load, adv, clr;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [RW-1:0]          ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0]   rd_start, rd_sum;
  logic [CNT_W-1:0]       rd_ent;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign in_ts     = TIME_BITS'(in_timestamp);
  assign in_tab    = (int'(in_scope_id) < SCOPE_COUNT);
  assign ev_tab    = (int'(ev_sid_r) < SCOPE_COUNT);
  assign in_sa     = AW'(in_scope_id);
  assign ev_sa     = AW'(ev_sid_r);
  assign ev_valid  = ev_tab && child_valid_r[ev_sa];
  assign ev_tgt    = (ev_sid_r == tgt_r);
  assign dbt_up    = (tnest_r != '0) ? inc_sat8(dbt_r) : dbt_r;
  assign idx_bit   = SCOPE_COUNT'(1) << idx_r;
  assign can_load  = !out_valid_r || out_ready;

  assign rd_start  = ram_rdata[TIME_BITS-1:0];
  assign rd_sum    = ram_rdata[2*TIME_BITS-1:TIME_BITS];
  assign rd_ent    = ram_rdata[RW-1:2*TIME_BITS];

  scp_ram #(
    .WIDTH (RW),
    .DEPTH (SCOPE_COUNT)
  ) u_child_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    root_depth_nxt  = root_depth_r;
    tnest_nxt       = tnest_r;
    dbt_nxt         = dbt_r;
    tstart_nxt      = tstart_r;
    tsum_nxt        = tsum_r;
    tent_nxt        = tent_r;
    child_valid_nxt = child_valid_r;
    root_seen_nxt   = root_seen_r;
    idx_nxt         = idx_r;
    out_load        = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_scope_nxt   = out_scope_r;
    out_time_nxt    = out_time_r;
    out_cnt_nxt     = out_cnt_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = ev_sa;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = in_sa;
    adv             = 1'b0;
    clr             = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_FRAME) begin
            if (kind_r == PK_CALL) begin
              state_nxt = S_DTGT;
            end else if (kind_r == PK_DISC && root_seen_r != '0) begin
              state_nxt = S_SCAN;
              idx_nxt   = '0;
            end else begin
              clr = 1'b1;
            end
          end else if (in_mode != MODE_NONE) begin
            if (kind_r == PK_DISC) begin
              if (in_mode == MODE_ENTER) begin
                root_depth_nxt = inc_sat8(root_depth_r);
                if (inc_sat8(root_depth_r) == DEPTH_W'(1) && in_tab) begin
                  root_seen_nxt[in_sa] = 1'b1;
                end
              end else begin
                root_depth_nxt = dec_hold8(root_depth_r);
              end
            end else if (kind_r == PK_CALL) begin
              ram_re    = 1'b1;
              state_nxt = S_EXEC;
            end
          end
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        if (!ev_leave_r) begin
          dbt_nxt = dbt_up;
          if (ev_tgt) begin
            tnest_nxt = inc_sat8(tnest_r);
            if (tnest_r == '0) begin
              tstart_nxt = ev_ts_r;
              tent_nxt   = inc_sat16(tent_r);
            end
          end else if (dbt_up == DEPTH_W'(1) && ev_tab) begin
            child_valid_nxt[ev_sa] = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = {inc_sat16(ev_valid ? rd_ent : '0),
                         (ev_valid ? rd_sum : '0), ev_ts_r};
          end
        end else begin
          if (ev_tgt) begin
            if (tnest_r == DEPTH_W'(1)) begin
              tnest_nxt = '0;
              tsum_nxt  = tsum_r + (ev_ts_r - tstart_r);
            end else if (tnest_r != '0) begin
              tnest_nxt = tnest_r - DEPTH_W'(1);
              dbt_nxt   = dec_hold8(dbt_r);
            end
          end else begin
            if (tnest_r != '0) begin
              dbt_nxt = dec_hold8(dbt_r);
            end
            if (tnest_r != '0 && dbt_r == DEPTH_W'(1) && ev_valid) begin
              ram_we    = 1'b1;
              ram_wdata = {rd_ent, rd_sum + (ev_ts_r - rd_start), rd_start};
            end
          end
        end
      end

      S_DTGT: begin
        if (can_load) begin
          out_load      = 1'b1;
          out_kind_nxt  = RK_TARGET;
          out_scope_nxt = tgt_r;
          out_time_nxt  = TS_W'(tsum_r);
          out_cnt_nxt   = tent_r;
          out_last_nxt  = (child_valid_r == '0);
          if (child_valid_r == '0) begin
            clr = 1'b1;
          end else begin
            state_nxt = S_SCAN;
            idx_nxt   = '0;
          end
        end
      end

      S_SCAN: begin
        if (kind_r == PK_CALL && child_valid_r[idx_r]) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r;
          state_nxt = S_CEMIT;
        end else if (kind_r == PK_DISC && root_seen_r[idx_r]) begin
          if (can_load) begin
            out_load      = 1'b1;
            out_kind_nxt  = RK_ROOT;
            out_scope_nxt = ID_W'(idx_r);
            out_time_nxt  = '0;
            out_cnt_nxt   = '0;
            out_last_nxt  = ((root_seen_r & ~idx_bit) == '0);
            root_seen_nxt = root_seen_r & ~idx_bit;
            if ((root_seen_r & ~idx_bit) == '0) begin
              clr = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
        end else begin
          adv = 1'b1;
        end
      end

      S_CEMIT: begin
        if (can_load) begin
          out_load        = 1'b1;
          out_kind_nxt    = RK_CHILD;
          out_scope_nxt   = ID_W'(idx_r);
          out_time_nxt    = TS_W'(rd_sum);
          out_cnt_nxt     = rd_ent;
          out_last_nxt    = ((child_valid_r & ~idx_bit) == '0);
          child_valid_nxt = child_valid_r & ~idx_bit;
          if ((child_valid_r & ~idx_bit) == '0) begin
            clr = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adv) begin
      if (idx_r == LAST_IDX) begin
        clr = 1'b1;
      end else begin
        idx_nxt   = idx_r + AW'(1);
        state_nxt = S_SCAN;
      end
    end

    if (clr) begin
      state_nxt       = S_IDLE;
      root_depth_nxt  = '0;
      tnest_nxt       = '0;
      dbt_nxt         = '0;
      tstart_nxt      = '0;
      tsum_nxt        = '0;
      tent_nxt        = '0;
      child_valid_nxt = '0;
      root_seen_nxt   = '0;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      kind_r        <= '0;
      tgt_r         <= '0;
      root_depth_r  <= '0;
      tnest_r       <= '0;
      dbt_r         <= '0;
      tstart_r      <= '0;
      tsum_r        <= '0;
      tent_r        <= '0;
      child_valid_r <= '0;
      root_seen_r   <= '0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      root_depth_r  <= root_depth_nxt;
      tnest_r       <= tnest_nxt;
      dbt_r         <= dbt_nxt;
      tstart_r      <= tstart_nxt;
      tsum_r        <= tsum_nxt;
      tent_r        <= tent_nxt;
      child_valid_r <= child_valid_nxt;
      root_seen_r   <= root_seen_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PROFILE_KIND: kind_r <= cfg_data[KIND_W-1:0];
          CFG_TARGET_SCOPE: tgt_r  <= cfg_data[ID_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_leave_r <= (in_mode == MODE_LEAVE);
      ev_sid_r   <= in_scope_id;
      ev_ts_r    <= in_ts;
    end
    out_kind_r  <= out_kind_nxt;
    out_scope_r <= out_scope_nxt;
    out_time_r  <= out_time_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_scope = out_scope_r;
  assign out_total_time   = out_time_r;
  assign out_enter_count  = out_cnt_r;
  assign out_last         = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result word overwritten while held");

  a_read_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re && state_r == S_IDLE) |=> (state_r == S_EXEC))
    else $error("table read not followed by write-back cycle");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CEMIT) |-> child_valid_r[idx_r])
    else $error("emitting an invalid child entry");

  a_dump_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DTGT || state_r == S_SCAN || state_r == S_CEMIT) && state_nxt == S_IDLE)
    |=> (child_valid_r == '0 && root_seen_r == '0 && tnest_r == '0))
    else $error("frame dump left state behind");

endmodule

`default_nettype wire
